// ----- rtl/tmca_pkg.sv -----
// tmca_pkg: shared types and constants of the cascaded transfer-matrix accumulator
// holds the complex element and matrix types, op codes and default parameters
// no dependencies
`default_nettype none

package tmca_pkg;

  localparam int DATA_W        = 32;
  localparam int IDX_W         = 10;
  localparam int CNT_W         = 11;
  localparam int NUM_FREQS_DEF = 1024;
  localparam int FRAC_BITS_DEF = 20;

  localparam logic [CNT_W-1:0] ACTIVE_FREQS_RST = 11'd1024;

  // item operation codes
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_MUL  = 1'b1
  } op_t;

  // one complex element, Q12.20 by default
  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } cplx_t;

  // 2x2 matrix, element (i,j) at index i*2+j
  typedef cplx_t [3:0] mat_t;

  localparam int MAT_W = $bits(mat_t);

  // load enables of one element lane
  typedef struct packed {
    logic ld_prod;
    logic ld_sum;
  } lane_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/tmca_if.sv -----
// channel interfaces of the cascaded transfer-matrix accumulator
// item, result and configuration channels with valid/ready handshakes
// depends on tmca_pkg
`default_nettype none

interface tmca_item_if;
  import tmca_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [IDX_W-1:0]         freq_index;
  logic signed [DATA_W-1:0] t11_re;
  logic signed [DATA_W-1:0] t12_re;
  logic signed [DATA_W-1:0] t21_re;
  logic signed [DATA_W-1:0] t22_re;
  logic signed [DATA_W-1:0] t11_im;
  logic signed [DATA_W-1:0] t12_im;
  logic signed [DATA_W-1:0] t21_im;
  logic signed [DATA_W-1:0] t22_im;

  modport source (
    output valid, op, freq_index, t11_re, t12_re, t21_re, t22_re,
           t11_im, t12_im, t21_im, t22_im,
    input  ready
  );
  modport sink (
    input  valid, op, freq_index, t11_re, t12_re, t21_re, t22_re,
           t11_im, t12_im, t21_im, t22_im,
    output ready
  );
endinterface

interface tmca_result_if;
  import tmca_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         out_index;
  logic signed [DATA_W-1:0] p11_re;
  logic signed [DATA_W-1:0] p12_re;
  logic signed [DATA_W-1:0] p21_re;
  logic signed [DATA_W-1:0] p22_re;
  logic signed [DATA_W-1:0] p11_im;
  logic signed [DATA_W-1:0] p12_im;
  logic signed [DATA_W-1:0] p21_im;
  logic signed [DATA_W-1:0] p22_im;
  logic                     saturated;
  logic                     index_error;

  modport source (
    output valid, out_index, p11_re, p12_re, p21_re, p22_re,
           p11_im, p12_im, p21_im, p22_im, saturated, index_error,
    input  ready
  );
  modport sink (
    input  valid, out_index, p11_re, p12_re, p21_re, p22_re,
           p11_im, p12_im, p21_im, p22_im, saturated, index_error,
    output ready
  );
endinterface

interface tmca_cfg_if;
  import tmca_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/tmca_ram.sv -----
// tmca_ram: generic single-write, single-read memory with registered read data
// no reset, contents undefined until written
// no dependencies
`default_nettype none

module tmca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tmca_lane.sv -----
// tmca_lane: one element of the 2x2 complex matrix product
// stage 1 registers eight 32x32 products, stage 2 the truncated partial sums,
// then a combinational final add with saturation; depends on tmca_pkg
`default_nettype none

module tmca_lane #(
  parameter int FRAC_BITS = tmca_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  tmca_pkg::lane_ctl_t ctl,
  input  tmca_pkg::cplx_t     a0,
  input  tmca_pkg::cplx_t     a1,
  input  tmca_pkg::cplx_t     b0,
  input  tmca_pkg::cplx_t     b1,
  output tmca_pkg::cplx_t     p,
  output logic                sat
);
  import tmca_pkg::*;

  localparam int PROD_W = 2 * DATA_W;
  localparam int TW     = PROD_W - FRAC_BITS;
  localparam int SW     = TW + 2;

  logic signed [PROD_W-1:0] rr0, ii0, ri0, ir0;
  logic signed [PROD_W-1:0] rr1, ii1, ri1, ir1;
  logic signed [TW:0]       re0, re1, im0, im1;
  logic signed [SW-1:0]     sum_re, sum_im;
  logic                     sat_re, sat_im;

  // floor shift by the fraction width
  function automatic logic signed [TW-1:0] trunc_p(input logic signed [PROD_W-1:0] v);
    return v[PROD_W-1:FRAC_BITS];
  endfunction

  // clip a wide sum to the 32-bit range
  function automatic logic [DATA_W:0] clip(input logic signed [SW-1:0] v);
    logic [SW-DATA_W:0] hi;
    logic               ovf;
    hi  = v[SW-1:DATA_W-1];
    ovf = !(&hi) && (|hi);
    if (!ovf) begin
      return {1'b0, v[DATA_W-1:0]};
    end else if (v[SW-1]) begin
      return {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  // product stage
  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      rr0 <= a0.re * b0.re;
      ii0 <= a0.im * b0.im;
      ri0 <= a0.re * b0.im;
      ir0 <= a0.im * b0.re;
      rr1 <= a1.re * b1.re;
      ii1 <= a1.im * b1.im;
      ri1 <= a1.re * b1.im;
      ir1 <= a1.im * b1.re;
    end
  end

  // truncated partial sums, one per k
  always_ff @(posedge clk) begin
    if (ctl.ld_sum) begin
      re0 <= (TW+1)'(trunc_p(rr0)) - (TW+1)'(trunc_p(ii0));
      re1 <= (TW+1)'(trunc_p(rr1)) - (TW+1)'(trunc_p(ii1));
      im0 <= (TW+1)'(trunc_p(ri0)) + (TW+1)'(trunc_p(ir0));
      im1 <= (TW+1)'(trunc_p(ri1)) + (TW+1)'(trunc_p(ir1));
    end
  end

  // final add and saturation
  always_comb begin
    sum_re = SW'(re0) + SW'(re1);
    sum_im = SW'(im0) + SW'(im1);
    {sat_re, p.re} = clip(sum_re);
    {sat_im, p.im} = clip(sum_im);
    sat = sat_re || sat_im;
  end

endmodule

`default_nettype wire

// ----- rtl/t_matrix_cascade_accumulator_top.sv -----
// an item passes stages 1 to 3 and then the output register before its result is valid
// throughput: one item per cycle unless the result side stalls; a multiply to a frequency
// point still held in the three internal stages waits for its write-back, as set by the
// store's single read port and write-back at the end
// reset: clears all valid bits and sets active_freqs to 1024; the matrix store
// is not cleared and holds undefined data until a load writes an entry
`default_nettype none

module t_matrix_cascade_accumulator_top #(
  parameter int NUM_FREQS = tmca_pkg::NUM_FREQS_DEF,
  parameter int FRAC_BITS = tmca_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  tmca_item_if.sink     item,
  tmca_result_if.source result,
  tmca_cfg_if.sink      cfg
);
  import tmca_pkg::*;

  localparam int ADDR_W = NUM_FREQS > 1 ? $clog2(NUM_FREQS) : 1;

  logic [CNT_W-1:0] active_freqs;

  // pipeline registers
  logic             v1, v2, v3, ov;
  op_t              op1, op2, op3;
  logic             err1, err2, err3;
  logic [IDX_W-1:0] idx1, idx2, idx3;
  mat_t             t1, t2, t3;

  // output register
  logic [IDX_W-1:0] o_idx;
  mat_t             o_mat;
  logic             o_sat;
  logic             o_err;

  logic             ld1, ld2, ld3, ld_o;
  logic             acc, err_in, hazard;
  op_t              op_in;
  mat_t             t_in;
  logic [MAT_W-1:0] rdata;
  mat_t             a_mat;
  mat_t             lane_mat;
  logic [3:0]       lane_sat;
  lane_ctl_t        lane_ctl;
  mat_t             fin_mat;
  logic             fin_sat;

  // configuration register, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_freqs <= ACTIVE_FREQS_RST;
    end else if (cfg.valid) begin
      active_freqs <= cfg.data;
    end
  end

  // incoming item
  always_comb begin
    op_in     = op_t'(item.op);
    t_in[0]   = '{re: item.t11_re, im: item.t11_im};
    t_in[1]   = '{re: item.t12_re, im: item.t12_im};
    t_in[2]   = '{re: item.t21_re, im: item.t21_im};
    t_in[3]   = '{re: item.t22_re, im: item.t22_im};
    err_in    = ({1'b0, item.freq_index} >= active_freqs) ||
                (32'(item.freq_index) >= 32'(NUM_FREQS));
    // a multiply must read an entry after all earlier writes to it
    hazard    = (op_in == OP_MUL) && !err_in && (
                  (v1 && !err1 && idx1 == item.freq_index) ||
                  (v2 && !err2 && idx2 == item.freq_index) ||
                  (v3 && !err3 && idx3 == item.freq_index));
  end

  // stage load enables, bubbles collapse
  assign ld_o       = !ov || result.ready;
  assign ld3        = !v3 || ld_o;
  assign ld2        = !v2 || ld3;
  assign ld1        = !v1 || ld2;
  assign item.ready = ld1 && !hazard;
  assign acc        = item.valid && item.ready;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (ld1) begin
        v1 <= acc;
      end
      if (ld2) begin
        v2 <= v1;
      end
      if (ld3) begin
        v3 <= v2;
      end
      if (ld_o) begin
        ov <= v3;
      end
    end
  end

  // side data carried along the stages
  always_ff @(posedge clk) begin
    if (ld1) begin
      op1  <= op_in;
      err1 <= err_in;
      idx1 <= item.freq_index;
      t1   <= t_in;
    end
    if (ld2) begin
      op2  <= op1;
      err2 <= err1;
      idx2 <= idx1;
      t2   <= t1;
    end
    if (ld3) begin
      op3  <= op2;
      err3 <= err2;
      idx3 <= idx2;
      t3   <= t2;
    end
  end

  // accumulator store, read on entry, written when a result for an accepted index is registered
  tmca_ram #(
    .WIDTH (MAT_W),
    .DEPTH (NUM_FREQS)
  ) u_store (
    .clk   (clk),
    .we    (ld_o && v3 && !err3),
    .waddr (ADDR_W'(idx3)),
    .wdata (fin_mat),
    .re    (ld1),
    .raddr (ADDR_W'(item.freq_index)),
    .rdata (rdata)
  );

  assign a_mat            = mat_t'(rdata);
  assign lane_ctl.ld_prod = ld2;
  assign lane_ctl.ld_sum  = ld3;

  // one lane per product element, row of the accumulator times column of the item
  for (genvar e = 0; e < 4; e++) begin : g_lane
    localparam int I = e / 2;
    localparam int J = e % 2;
    tmca_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk (clk),
      .ctl (lane_ctl),
      .a0  (a_mat[I*2]),
      .a1  (a_mat[I*2+1]),
      .b0  (t1[J]),
      .b1  (t1[2+J]),
      .p   (lane_mat[e]),
      .sat (lane_sat[e])
    );
  end

  // result select: rejected index, load or product
  always_comb begin
    if (err3) begin
      fin_mat = '0;
      fin_sat = 1'b0;
    end else if (op3 == OP_LOAD) begin
      fin_mat = t3;
      fin_sat = 1'b0;
    end else begin
      fin_mat = lane_mat;
      fin_sat = |lane_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_o) begin
      o_idx <= idx3;
      o_mat <= fin_mat;
      o_sat <= fin_sat;
      o_err <= err3;
    end
  end

  // result channel
  assign result.valid       = ov;
  assign result.out_index   = o_idx;
  assign result.p11_re      = o_mat[0].re;
  assign result.p12_re      = o_mat[1].re;
  assign result.p21_re      = o_mat[2].re;
  assign result.p22_re      = o_mat[3].re;
  assign result.p11_im      = o_mat[0].im;
  assign result.p12_im      = o_mat[1].im;
  assign result.p21_im      = o_mat[2].im;
  assign result.p22_im      = o_mat[3].im;
  assign result.saturated   = o_sat;
  assign result.index_error = o_err;

endmodule

`default_nettype wire

// ----- dv/t_matrix_cascade_accumulator_top_test.sv -----
// testbench of the cascaded transfer-matrix accumulator: predicts every result of the
// block from its own copy of the per-frequency matrix store and checks it field by field
// depends on tmca_pkg, tmca_if and t_matrix_cascade_accumulator_top
`timescale 1ns / 1ps

module t_matrix_cascade_accumulator_top_test;
  import tmca_pkg::*;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0010_0000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT_RESULT = 100;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    mat_t             mat;
    logic             sat;
    logic             err;
  } product_result_t;

  // accumulated matrix per frequency point and the results still owed by the block
  class matrix_product_board;
    mat_t             acc_store [NUM_FREQS_DEF];
    logic [CNT_W-1:0] active_count;
    product_result_t  pending_products [$];
    int               mismatches;

    function new();
      active_count = ACTIVE_FREQS_RST;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_products.size();
    endfunction

    // real product, truncated toward minus infinity
    function longint scaled_product(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return p >>> FRAC_BITS_DEF;
    endfunction

    function logic signed [DATA_W-1:0] clamp(longint v, inout bit sat);
      if (v > longint'(Q_MAX)) begin
        sat = 1'b1;
        return Q_MAX;
      end
      if (v < longint'(Q_MIN)) begin
        sat = 1'b1;
        return Q_MIN;
      end
      return v[DATA_W-1:0];
    endfunction

    function product_result_t predict_product(op_t op, logic [IDX_W-1:0] idx, mat_t t);
      product_result_t res;
      mat_t acc;
      longint re_sum;
      longint im_sum;
      bit sat;
      res.index = idx;
      res.mat = '0;
      res.sat = 1'b0;
      res.err = 1'b0;
      // rejected point: store untouched, matrix zero
      if (idx >= active_count) begin
        res.err = 1'b1;
        return res;
      end
      if (op == OP_LOAD) begin
        res.mat = t;
      end else begin
        acc = acc_store[idx];
        sat = 1'b0;
        for (int i = 0; i < 2; i++) begin
          for (int j = 0; j < 2; j++) begin
            re_sum = 0;
            im_sum = 0;
            for (int k = 0; k < 2; k++) begin
              re_sum += scaled_product(acc[i*2+k].re, t[k*2+j].re)
                      - scaled_product(acc[i*2+k].im, t[k*2+j].im);
              im_sum += scaled_product(acc[i*2+k].re, t[k*2+j].im)
                      + scaled_product(acc[i*2+k].im, t[k*2+j].re);
            end
            res.mat[i*2+j].re = clamp(re_sum, sat);
            res.mat[i*2+j].im = clamp(im_sum, sat);
          end
        end
        res.sat = sat;
      end
      acc_store[idx] = res.mat;
      return res;
    endfunction

    function void note_item(op_t op, logic [IDX_W-1:0] idx, mat_t t);
      pending_products.push_back(predict_product(op, idx, t));
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch %s: expected %h got %h at %0t", name, want, got, $realtime);
      end
    endfunction

    function void check_result(logic [IDX_W-1:0] idx, mat_t m, logic sat, logic err);
      product_result_t want;
      if (pending_products.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: result for point %0d with none outstanding at %0t", idx,
                   $realtime);
        return;
      end
      want = pending_products.pop_front();
      compare_field("out_index", 32'(want.index), 32'(idx));
      for (int e = 0; e < 4; e++) begin
        compare_field($sformatf("p%0d%0d_re", e / 2 + 1, e % 2 + 1), want.mat[e].re, m[e].re);
        compare_field($sformatf("p%0d%0d_im", e / 2 + 1, e % 2 + 1), want.mat[e].im, m[e].im);
      end
      compare_field("saturated", 32'(want.sat), 32'(sat));
      compare_field("index_error", 32'(want.err), 32'(err));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  tmca_item_if   item_ch ();
  tmca_result_if result_ch ();
  tmca_cfg_if    cfg_ch ();

  t_matrix_cascade_accumulator_top dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  matrix_product_board board;
  logic [CNT_W-1:0]    current_active;
  bit                  loaded [NUM_FREQS_DEF];
  bit                  sender_burst;
  logic [IDX_W-1:0]    last_idx;

  // clock, 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // transfer monitor on both channels
  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (result_ch.valid && result_ch.ready) begin
        board.check_result(result_ch.out_index,
                           {{result_ch.p22_re, result_ch.p22_im},
                            {result_ch.p21_re, result_ch.p21_im},
                            {result_ch.p12_re, result_ch.p12_im},
                            {result_ch.p11_re, result_ch.p11_im}},
                           result_ch.saturated, result_ch.index_error);
      end
      if (item_ch.valid && item_ch.ready) begin
        board.note_item(op_t'(item_ch.op), item_ch.freq_index,
                        {{item_ch.t22_re, item_ch.t22_im},
                         {item_ch.t21_re, item_ch.t21_im},
                         {item_ch.t12_re, item_ch.t12_im},
                         {item_ch.t11_re, item_ch.t11_im}});
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] random_element();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return Q_MAX;
      2: return Q_MIN;
      3: return '0;
      default: return 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
    endcase
  endfunction

  function automatic mat_t random_matrix();
    mat_t m;
    for (int e = 0; e < 4; e++) begin
      m[e].re = random_element();
      m[e].im = random_element();
    end
    return m;
  endfunction

  function automatic mat_t uniform_matrix(logic signed [DATA_W-1:0] re,
                                          logic signed [DATA_W-1:0] im);
    mat_t m;
    for (int e = 0; e < 4; e++) begin
      m[e].re = re;
      m[e].im = im;
    end
    return m;
  endfunction

  // one item transfer, entered and left at a falling edge
  task automatic send_item(op_t op, logic [IDX_W-1:0] idx, mat_t m);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.op         <= op;
    item_ch.freq_index <= idx;
    item_ch.t11_re     <= m[0].re;
    item_ch.t12_re     <= m[1].re;
    item_ch.t21_re     <= m[2].re;
    item_ch.t22_re     <= m[3].re;
    item_ch.t11_im     <= m[0].im;
    item_ch.t12_im     <= m[1].im;
    item_ch.t21_im     <= m[2].im;
    item_ch.t22_im     <= m[3].im;
    do @(posedge clk); while (!item_ch.ready);
    if (op == OP_LOAD && idx < current_active)
      loaded[idx] = 1'b1;
    last_idx = idx;
    @(negedge clk);
  endtask

  // wait until every result is back, then let the pipeline settle
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_active_count(logic [CNT_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    board.active_count = value;
    current_active = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // random items: mostly load-then-multiply chains on live points, some rejected points
  task automatic run_random_phase(int count);
    logic [IDX_W-1:0] idx;
    int hi;
    op_t op;
    for (int n = 0; n < count; n++) begin
      hi = (current_active > NUM_FREQS_DEF) ? NUM_FREQS_DEF - 1 : int'(current_active) - 1;
      case ($urandom_range(0, 9))
        0, 1, 2: idx = last_idx;
        3: idx = IDX_W'($urandom_range(0, NUM_FREQS_DEF - 1));
        default: idx = (hi < 0) ? IDX_W'($urandom_range(0, NUM_FREQS_DEF - 1))
                                : IDX_W'($urandom_range(0, hi));
      endcase
      if (idx < current_active && !loaded[idx])
        op = OP_LOAD;
      else
        op = ($urandom_range(0, 9) < 3) ? OP_LOAD : OP_MUL;
      send_item(op, idx, random_matrix());
    end
  endtask

  // result receiver with random stalls and one long hold-off
  initial begin
    int results_taken;
    int stall;
    bit recv_burst;
    bit hold_done;
    results_taken = 0;
    recv_burst = 1'b0;
    hold_done = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (!hold_done && results_taken >= HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (results_taken % 64 == 0)
        recv_burst = ($urandom_range(0, 3) == 0);
      stall = recv_burst ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      results_taken++;
      @(negedge clk);
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // main sequence
  initial begin
    mat_t ident;
    logic [CNT_W-1:0] phase_active [8];
    board = new();
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.op = OP_LOAD;
    item_ch.freq_index = '0;
    item_ch.t11_re = '0;
    item_ch.t12_re = '0;
    item_ch.t21_re = '0;
    item_ch.t22_re = '0;
    item_ch.t11_im = '0;
    item_ch.t12_im = '0;
    item_ch.t21_im = '0;
    item_ch.t22_im = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    current_active = ACTIVE_FREQS_RST;
    sender_burst = 1'b0;
    last_idx = '0;
    phase_active = '{11'd1024, 11'd1, 11'd2047, 11'd0, 11'd300, 11'd16, 11'd1024, 11'd0};
    phase_active[7] = CNT_W'($urandom_range(1, NUM_FREQS_DEF));
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: saturation both ways, identity, rounding toward minus infinity
    write_active_count(11'd1024);
    ident = uniform_matrix('0, '0);
    ident[0].re = Q_ONE;
    ident[3].re = Q_ONE;
    send_item(OP_LOAD, 10'd0, uniform_matrix(Q_MAX, Q_MAX));
    send_item(OP_MUL, 10'd0, uniform_matrix(Q_MAX, Q_MAX));
    send_item(OP_LOAD, 10'd1023, uniform_matrix(Q_MIN, Q_MIN));
    send_item(OP_MUL, 10'd1023, uniform_matrix(Q_MIN, Q_MIN));
    send_item(OP_LOAD, 10'd5, ident);
    send_item(OP_MUL, 10'd5, random_matrix());
    send_item(OP_MUL, 10'd5, ident);
    send_item(OP_LOAD, 10'd7, uniform_matrix(32'sd1, '0));
    send_item(OP_MUL, 10'd7, uniform_matrix(-32'sd1, '0));
    send_item(OP_MUL, 10'd7, uniform_matrix('0, -32'sd1));
    send_item(OP_LOAD, 10'd9, uniform_matrix(Q_MAX, Q_MAX));
    send_item(OP_MUL, 10'd9, uniform_matrix(Q_MIN, Q_MIN));
    send_item(OP_LOAD, 10'd512, uniform_matrix('0, '0));
    send_item(OP_MUL, 10'd512, uniform_matrix(Q_MIN, Q_MAX));
    drain();

    // directed: rejected points with one active point
    write_active_count(11'd1);
    send_item(OP_LOAD, 10'd0, random_matrix());
    send_item(OP_LOAD, 10'd1, random_matrix());
    send_item(OP_MUL, 10'd1023, random_matrix());
    send_item(OP_MUL, 10'd0, random_matrix());
    drain();

    // random phases over several point counts
    for (int p = 0; p < 8; p++) begin
      write_active_count(phase_active[p]);
      sender_burst = (p == 0) || ($urandom_range(0, 3) == 0);
      run_random_phase((phase_active[p] == 0) ? 60 : 220);
      drain();
    end

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
